FILE: rtl/sft_pkg.sv
// ----------------------------------------------------------------------------
// sft_pkg
// shared types and constants of the slide/fade transition compositor
// ----------------------------------------------------------------------------
package sft_pkg;

  // brightness percentages
  localparam int PCT_FULL      = 100;
  localparam int PCT_OLD_DROP  = 50;
  localparam int PCT_NEW_START = 60;
  localparam int PCT_NEW_RISE  = 40;

  // reset values of the derived percentages
  localparam logic [6:0] OLD_PCT_RESET = 7'(PCT_FULL);
  localparam logic [6:0] NEW_PCT_RESET = 7'(PCT_NEW_START);

  // x / 100 == (x * 5243) >> 19 for every x below 6400
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  // numerator width of elapsed * 50 with elapsed below 256
  localparam int PNUM_W = 14;

  // decoupling queue
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [6:0] old_pct;
    logic [6:0] new_pct;
  } sft_pct_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [6:0]  pct;
    logic        last;
  } sft_entry_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SQR   = 6'b000010,
    ST_CUBE  = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_SUM   = 6'b010000,
    ST_FIN   = 6'b100000
  } sft_state_e;

endpackage

FILE: rtl/slide_fade_transition_pixel.sv
// ----------------------------------------------------------------------------
// slide_fade_transition_pixel
// composes one row stream of a sliding, fading page transition
// ----------------------------------------------------------------------------
// channel  dir  handshake                   payload
// s_axis   in   s_axis_tvalid/tready        tdata column, source_pixel; tuser from_new_page
// m_axis   out  m_axis_tvalid/tready        tdata out_pixel; tlast row_last
// cfg      in   cfg_valid_i/cfg_ready_o     cfg_data_i elapsed_time
//
// one pixel per clock sustained while no derivation runs and m_axis takes every pixel;
// a visible pixel passes the queue, the product stage and the output register
// on its way to m_axis. an elapsed time write reruns the derivation: input and cfg
// stall while it steps through square, cube, scale, sum and finish.
// after reset shift is 0, old page at 100 percent, new page at 60 percent.
// a stalled output fills the 4-entry queue before s_axis_tready drops.
// ----------------------------------------------------------------------------
module slide_fade_transition_pixel import sft_pkg::*; #(
  parameter int WIDTH    = 240,
  parameter int DURATION = 160
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // column [7:0], source_pixel [23:8]
  input  logic        s_axis_tuser,   // from_new_page
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // out_pixel [15:0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);

  localparam int SW = $clog2(WIDTH + 1);

  logic          busy;
  logic [SW-1:0] shift;
  sft_pct_t      pct;
  logic          full, empty, push, pop;
  sft_entry_t    push_entry, pop_entry;

  sft_param_unit #(
    .WIDTH    (WIDTH),
    .DURATION (DURATION)
  ) u_param (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (busy),
    .shift_o     (shift),
    .pct_o       (pct)
  );

  sft_front #(
    .WIDTH (WIDTH)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .busy_i        (busy),
    .shift_i       (shift),
    .pct_i         (pct),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (push_entry)
  );

  sft_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .empty_o (empty)
  );

  sft_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .entry_i       (pop_entry),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_busy_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready && !cfg_ready_o) else $error("request taken during derivation");

  a_cfg_starts_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> busy) else $error("elapsed write did not start derivation");

endmodule

FILE: rtl/sft_param_unit.sv
// ----------------------------------------------------------------------------
// sft_param_unit
// takes the elapsed time and derives eased shift and fade percentages
// ----------------------------------------------------------------------------
module sft_param_unit import sft_pkg::*; #(
  parameter int WIDTH    = 240,
  parameter int DURATION = 160,
  localparam int SW      = $clog2(WIDTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [7:0]    cfg_data_i,
  output logic          busy_o,
  output logic [SW-1:0] shift_o,
  output sft_pct_t      pct_o
);

  localparam int          DW   = $clog2(DURATION + 1);
  localparam logic [63:0] D3   = 64'(DURATION) * 64'(DURATION) * 64'(DURATION);
  localparam int          D3B  = $clog2(D3 + 64'd1);
  localparam int          D3W  = (D3B < 2) ? 2 : D3B;
  localparam int          NUMW = D3W + SW;
  localparam int          EW   = SW + 1;
  localparam int          CKW  = D3W + EW;
  // ceil(2^NUMW / D3) folded with the width, estimate is the quotient or one above
  localparam logic [63:0] MS   = ((64'd1 << NUMW) + D3 - 64'd1) / D3;
  localparam logic [63:0] KS   = 64'(WIDTH) * MS;
  localparam int          KW   = $clog2(KS + 64'd1);
  localparam int          PW   = D3W + KW;
  // ceil(2^PP / duration), exact for every percent numerator
  localparam int          PP   = PNUM_W + DW;
  localparam logic [63:0] MP   = ((64'd1 << PP) + 64'(DURATION) - 64'd1) / 64'(DURATION);
  localparam int          MPW  = $clog2(MP + 64'd1);
  localparam int          PQW  = PNUM_W + MPW;

  sft_state_e state_q, state_d;
  logic [SW-1:0]  shift_q, shift_d;
  sft_pct_t       pct_q, pct_d;

  logic [7:0]        e_q;
  logic [2*DW-1:0]   r2_q;
  logic [D3W-1:0]    r3_q;
  logic [PNUM_W-1:0] pno_q, pnn_q;
  logic [6:0]        pqo_q, pqn_q;
  logic [EW-1:0]     est_q;
  logic [NUMW-1:0]   num_q;
  logic [CKW-1:0]    chk_q;

  logic [7:0]      e_clamp;
  logic [DW-1:0]   r_w;
  logic [2*DW-1:0] r2_w;
  logic [3*DW-1:0] r3_w;
  logic [D3W-1:0]  diff_w;
  logic [PW-1:0]   est_w;
  logic [PQW-1:0]  pqo_w, pqn_w;
  logic            over;

  assign e_clamp = (32'(cfg_data_i) > 32'(DURATION)) ? 8'(DURATION) : cfg_data_i;
  assign r_w     = DW'(DURATION) - DW'(e_q);
  assign r2_w    = {{DW{1'b0}}, r_w} * {{DW{1'b0}}, r_w};
  assign r3_w    = {{DW{1'b0}}, r2_q} * {{(2*DW){1'b0}}, r_w};
  assign diff_w  = D3W'(D3) - r3_q;

  assign est_w = PW'(diff_w) * PW'(KS);
  assign pqo_w = PQW'(pno_q) * PQW'(MP);
  assign pqn_w = PQW'(pnn_q) * PQW'(MP);
  assign over  = chk_q > CKW'(num_q);

  always_comb begin
    state_d = state_q;
    shift_d = shift_q;
    pct_d   = pct_q;
    case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          state_d = ST_SQR;
        end
      end
      ST_SQR:   state_d = ST_CUBE;
      ST_CUBE:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_SUM;
      ST_SUM:   state_d = ST_FIN;
      ST_FIN: begin
        state_d       = ST_IDLE;
        // drop the estimate by one when it overshoots
        shift_d       = SW'(est_q - EW'(over));
        pct_d.old_pct = 7'(PCT_FULL) - pqo_q;
        pct_d.new_pct = 7'(PCT_NEW_START) + pqn_q;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      shift_q       <= '0;
      pct_q.old_pct <= OLD_PCT_RESET;
      pct_q.new_pct <= NEW_PCT_RESET;
    end else begin
      state_q <= state_d;
      shift_q <= shift_d;
      pct_q   <= pct_d;
    end
  end

  // datapath of the derivation, one step per state
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          e_q <= e_clamp;
        end
      end
      ST_SQR: begin
        r2_q  <= r2_w;
        pno_q <= PNUM_W'(e_q) * PNUM_W'(PCT_OLD_DROP);
        pnn_q <= PNUM_W'(e_q) * PNUM_W'(PCT_NEW_RISE);
      end
      ST_CUBE: begin
        r3_q  <= D3W'(r3_w);
        pqo_q <= 7'(pqo_w >> PP);
        pqn_q <= 7'(pqn_w >> PP);
      end
      ST_SCALE: begin
        est_q <= EW'(est_w >> NUMW);
        num_q <= NUMW'(WIDTH) * NUMW'(diff_w);
      end
      ST_SUM: chk_q <= CKW'(est_q) * CKW'(D3);
      default: ;
    endcase
  end

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign busy_o      = (state_q != ST_IDLE);
  assign shift_o     = shift_q;
  assign pct_o       = pct_q;

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(shift_q) <= WIDTH) else $error("slide shift beyond row width");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pct_q.old_pct >= 7'(PCT_OLD_DROP) && pct_q.old_pct <= 7'(PCT_FULL) &&
    pct_q.new_pct >= 7'(PCT_NEW_START) && pct_q.new_pct <= 7'(PCT_FULL))
    else $error("fade percentage out of range");

endmodule

FILE: rtl/sft_front.sv
// ----------------------------------------------------------------------------
// sft_front
// accepts source pixels, decides visibility and row end, picks the percent
// ----------------------------------------------------------------------------
module sft_front import sft_pkg::*; #(
  parameter int WIDTH    = 240,
  localparam int SW      = $clog2(WIDTH + 1)
) (
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [23:0]   s_axis_tdata,
  input  logic          s_axis_tuser,
  input  logic          busy_i,
  input  logic [SW-1:0] shift_i,
  input  sft_pct_t      pct_i,
  input  logic          full_i,
  output logic          push_o,
  output sft_entry_t    entry_o
);

  localparam int CMPW = ((SW > 8) ? SW : 8) + 1;

  logic [CMPW-1:0] col_x, shift_x;
  logic            in_row, emit, last;

  assign col_x   = CMPW'(s_axis_tdata[7:0]);
  assign shift_x = CMPW'(shift_i);
  assign in_row  = 32'(col_x) < WIDTH;

  always_comb begin
    if (s_axis_tuser) begin
      emit = in_row && (col_x < shift_x);
      last = (col_x + 1'b1) == shift_x;
    end else begin
      emit = in_row && (col_x >= shift_x);
      last = (shift_i == '0) && (col_x == CMPW'(WIDTH - 1));
    end
  end

  assign s_axis_tready = !busy_i && !full_i;
  assign push_o        = s_axis_tvalid && s_axis_tready && emit;

  assign entry_o.pixel = s_axis_tdata[23:8];
  assign entry_o.pct   = s_axis_tuser ? pct_i.new_pct : pct_i.old_pct;
  assign entry_o.last  = last;

endmodule

FILE: rtl/sft_queue.sv
// ----------------------------------------------------------------------------
// sft_queue
// short fifo between classification and scaling
// ----------------------------------------------------------------------------
module sft_queue import sft_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  sft_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output sft_entry_t entry_o,
  output logic       empty_o
);

  sft_entry_t     mem_q [QDEPTH];
  logic [QPW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPW:0]   count_q, count_d;
  logic           do_push, do_pop;

  assign full_o  = count_q == (QPW+1)'(QDEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPW+1)'(QDEPTH)) else $error("queue occupancy overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    QPW'(wr_ptr_q - rd_ptr_q) == QPW'(count_q)) else $error("queue pointers lost track");

endmodule

FILE: rtl/sft_back.sv
// ----------------------------------------------------------------------------
// sft_back
// per-channel brightness scaling and the output register
// ----------------------------------------------------------------------------
module sft_back import sft_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  sft_entry_t  entry_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  logic        s1_v_q, out_v_q;
  logic [25:0] pr_q, pg_q, pb_q;
  logic        s1_last_q, out_last_q;
  logic [15:0] out_px_q;
  logic        out_en, s1_en;
  logic [25:0] qr, qg, qb;

  assign out_en = !out_v_q || m_axis_tready;
  assign s1_en  = !s1_v_q || out_en;
  assign pop_o  = !empty_i && s1_en;

  // divide by 100 through the reciprocal
  assign qr = pr_q * 26'(RECIP_100);
  assign qg = pg_q * 26'(RECIP_100);
  assign qb = pb_q * 26'(RECIP_100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_q <= !empty_i;
      end
      if (out_en) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pr_q      <= 26'(entry_i.pixel[15:11]) * 26'(entry_i.pct);
      pg_q      <= 26'(entry_i.pixel[10:5]) * 26'(entry_i.pct);
      pb_q      <= 26'(entry_i.pixel[4:0]) * 26'(entry_i.pct);
      s1_last_q <= entry_i.last;
    end
    if (out_en && s1_v_q) begin
      out_px_q   <= {qr[RECIP_SHIFT+4:RECIP_SHIFT], qg[RECIP_SHIFT+5:RECIP_SHIFT],
                     qb[RECIP_SHIFT+4:RECIP_SHIFT]};
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_px_q;
  assign m_axis_tlast  = out_last_q;

endmodule
